// File: sv/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
// Holds the sequencer state type, ASCII codes, BCD adjust constants and sizing helpers.
// No dependencies; compile this file first.
package sitda_pkg;

	// Default width of the signed input value.
	localparam int unsigned VALUE_BITS_DEF = 32;

	// ASCII codes that the converter emits.
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2d;

	// Double dabble adjust: a BCD digit of five or more gets three added before a shift.
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// Number of decimal digits of 2^(bits-1), the largest magnitude. 1233/4096 is log10(2).
	function automatic int unsigned digit_count(input int unsigned bits);
		return (((bits - 1) * 1233) >> 12) + 1;
	endfunction

endpackage

// File: sv/signed_int_to_decimal_ascii.sv
// An item keeps the sequencer busy through the convert, skip, optional sign and emit
// states; busy is high while it is not idle, and a new item is taken only in idle.
// The double dabble loop takes one input bit per cycle, then leading zeros drop one
// digit per cycle and the characters leave one per cycle, each registered.
// The receiver cannot stall.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and clears strobe.
module signed_int_to_decimal_ascii #(
	parameter int unsigned VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         strobe,
	output logic [7:0]                   character,
	output logic                         last
);

	localparam int unsigned NDIG = sitda_pkg::digit_count(VALUE_BITS);
	localparam int unsigned BW   = NDIG * 4;
	localparam int unsigned BCW  = $clog2(VALUE_BITS + 1);
	localparam int unsigned DCW  = $clog2(NDIG + 1);

	sitda_pkg::state_t state_q, state_d;

	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic [BW-1:0]         bcd_q;
	logic [BW-1:0]         bcd_step;
	logic [BCW-1:0]        bit_cnt_q;
	logic [DCW-1:0]        dig_cnt_q;
	logic [VALUE_BITS-1:0] uvalue;
	logic [VALUE_BITS-1:0] mag_in;
	logic [3:0]            top_digit;
	logic                  accept;
	logic                  do_load, do_convert, do_shift;
	logic                  strobe_d, last_d, strobe_q, last_q;
	logic [7:0]            char_d, char_q;

	assign accept    = start && !busy;
	assign busy      = (state_q != sitda_pkg::ST_IDLE);
	assign uvalue    = $unsigned(value);
	assign top_digit = bcd_q[BW-1 -: 4];

	// Magnitude of the input; the most negative value yields 2^(VALUE_BITS-1) exactly.
	assign mag_in = uvalue[VALUE_BITS-1] ? (~uvalue + VALUE_BITS'(1)) : uvalue;

	// Shared double dabble unit.
	sitda_bcd_step #(
		.NDIG (NDIG)
	) u_step (
		.bcd_in  (bcd_q),
		.bit_in  (mag_q[VALUE_BITS-1]),
		.bcd_out (bcd_step)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sitda_pkg::ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
		end
	end

	// Next state, datapath controls and the next result.
	always_comb begin
		state_d    = state_q;
		do_load    = 1'b0;
		do_convert = 1'b0;
		do_shift   = 1'b0;
		strobe_d   = 1'b0;
		last_d     = 1'b0;
		char_d     = sitda_pkg::ASCII_ZERO + {4'h0, top_digit};
		unique case (state_q)
			sitda_pkg::ST_IDLE: begin
				if (start) begin
					do_load = 1'b1;
					state_d = sitda_pkg::ST_CONVERT;
				end
			end
			sitda_pkg::ST_CONVERT: begin
				do_convert = 1'b1;
				if (bit_cnt_q == BCW'(1)) begin
					state_d = sitda_pkg::ST_SKIP;
				end
			end
			sitda_pkg::ST_SKIP: begin
				// Drop leading zero digits, keeping at least one digit.
				if (top_digit == 4'h0 && dig_cnt_q != DCW'(1)) begin
					do_shift = 1'b1;
				end else if (neg_q) begin
					state_d = sitda_pkg::ST_SIGN;
				end else begin
					state_d = sitda_pkg::ST_EMIT;
				end
			end
			sitda_pkg::ST_SIGN: begin
				strobe_d = 1'b1;
				char_d   = sitda_pkg::ASCII_MINUS;
				state_d  = sitda_pkg::ST_EMIT;
			end
			sitda_pkg::ST_EMIT: begin
				strobe_d = 1'b1;
				do_shift = 1'b1;
				if (dig_cnt_q == DCW'(1)) begin
					last_d  = 1'b1;
					state_d = sitda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sitda_pkg::ST_IDLE;
			end
		endcase
	end

	// Control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			if (do_load) begin
				bit_cnt_q <= BCW'(VALUE_BITS);
				dig_cnt_q <= DCW'(NDIG);
			end else begin
				if (do_convert) begin
					bit_cnt_q <= bit_cnt_q - BCW'(1);
				end
				if (do_shift) begin
					dig_cnt_q <= dig_cnt_q - DCW'(1);
				end
			end
		end
	end

	// Datapath: magnitude shifter, BCD digits and the result register.
	always_ff @(posedge clk) begin
		if (do_load) begin
			mag_q <= mag_in;
			neg_q <= uvalue[VALUE_BITS-1];
			bcd_q <= '0;
		end else if (do_convert) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= bcd_step;
		end else if (do_shift) begin
			bcd_q <= {bcd_q[BW-5:0], 4'h0};
		end
		char_q <= char_d;
		last_q <= last_d;
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

	// An accepted item keeps the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("block not busy after accepting an item");

	// The final character of a number is never followed at once by another one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("character emitted right after the final one");

	// Every character is a minus sign or a decimal digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (character == sitda_pkg::ASCII_MINUS) ||
			((character >= sitda_pkg::ASCII_ZERO) &&
			(character <= sitda_pkg::ASCII_ZERO + 8'd9)))
		else $error("character is neither a digit nor a minus sign");

	// A minus sign is never the final character.
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && character == sitda_pkg::ASCII_MINUS) |-> !last)
		else $error("minus sign flagged as the final character");

	// The digit counter never runs out while digits are still being emitted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sitda_pkg::ST_EMIT) |-> (dig_cnt_q != '0))
		else $error("digit counter empty during emission");

endmodule

// File: sv/sitda_bcd_step.sv
// One double dabble step: adjusts every BCD digit and shifts in one binary bit.
// This is the shared arithmetic unit that the converter uses once per cycle in its convert state.
// Depends on sitda_pkg.
module sitda_bcd_step #(
	parameter int unsigned NDIG = 10
) (
	input  logic [NDIG*4-1:0] bcd_in,
	input  logic              bit_in,
	output logic [NDIG*4-1:0] bcd_out
);

	logic [NDIG*4-1:0] adj;

	// Each digit is adjusted on its own, so the digits work in parallel.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_in[i*4 +: 4] >= sitda_pkg::BCD_ADJ_MIN) begin
				adj[i*4 +: 4] = bcd_in[i*4 +: 4] + sitda_pkg::BCD_ADJ_ADD;
			end else begin
				adj[i*4 +: 4] = bcd_in[i*4 +: 4];
			end
		end
	end

	// Shift the adjusted digits left by one bit and bring in the next binary bit.
	assign bcd_out = {adj[NDIG*4-2:0], bit_in};

endmodule
